@@ rtl/clcd_pkg.sv @@
// Shared constants, control-word types and microcode table of the character LCD interface.
package clcd_pkg;

    localparam int BUFFER_CHARS_DEF = 80;
    localparam int CELL_AW          = 7;

    localparam logic [2:0] REQ_STORE = 3'd0;
    localparam logic [2:0] REQ_FLUSH = 3'd1;
    localparam logic [2:0] REQ_INIT  = 3'd2;
    localparam logic [2:0] REQ_RAW   = 3'd3;
    localparam logic [2:0] REQ_CGRAM = 3'd4;
    localparam logic [2:0] REQ_DDRAM = 3'd5;

    localparam logic [1:0] REG_PANEL_KIND    = 2'd0;
    localparam logic [1:0] REG_CLEAR_AFTER   = 2'd1;
    localparam logic [1:0] REG_POWER_ON_WAIT = 2'd2;

    localparam logic [7:0]  CHAR_SPACE        = 8'h20;
    localparam logic [15:0] POWER_ON_WAIT_RST = 16'd15000;
    localparam logic [15:0] WAIT_SAT          = 16'd65534;

    // Waits after E falls, each delay already stretched by one tick.
    localparam logic [12:0] WAIT_NIB   = 13'd2;
    localparam logic [12:0] WAIT_BYTE  = 13'd61;
    localparam logic [12:0] WAIT_ADDR  = 13'd117;
    localparam logic [12:0] WAIT_CLEAR = 13'd2342;
    localparam logic [12:0] WAIT_INIT0 = 13'd6212;
    localparam logic [12:0] WAIT_INIT1 = 13'd212;

    localparam logic [3:0] PC_RAW   = 4'd0;
    localparam logic [3:0] PC_CGRAM = 4'd1;
    localparam logic [3:0] PC_DDRAM = 4'd2;
    localparam logic [3:0] PC_FLUSH = 4'd3;
    localparam logic [3:0] PC_INIT  = 4'd5;

    typedef enum logic [2:0] {
        SRC_CONST, SRC_RAW, SRC_CGRAM, SRC_DDRAM, SRC_ROW, SRC_CELL
    } src_t;

    typedef enum logic [1:0] {RS_CMD, RS_DATA, RS_REQ} rs_sel_t;

    typedef enum logic [2:0] {
        WT_BYTE, WT_ADDR, WT_CLEAR, WT_INIT0, WT_INIT1
    } wait_sel_t;

    typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_ROW} last_sel_t;

    typedef enum logic [1:0] {NXT_SEQ, NXT_ROW, NXT_END} next_sel_t;

    typedef struct packed {
        src_t       src;
        rs_sel_t    rs;
        logic       single;
        logic       first;
        wait_sel_t  wt;
        last_sel_t  lst;
        next_sel_t  nxt;
        logic [7:0] cbyte;
    } uop_t;

    typedef struct packed {
        logic               store;
        logic               rd;
        logic               clr;
        logic [CELL_AW-1:0] addr;
        logic [7:0]         data;
    } buf_cmd_t;

    function automatic uop_t uop_rom(input logic [3:0] pc);
        uop_t u;
        case (pc)
            4'd0:  u = '{SRC_RAW,   RS_REQ,  1'b0, 1'b0, WT_BYTE,  LAST_YES, NXT_END, 8'h00};
            4'd1:  u = '{SRC_CGRAM, RS_CMD,  1'b0, 1'b0, WT_ADDR,  LAST_YES, NXT_END, 8'h00};
            4'd2:  u = '{SRC_DDRAM, RS_CMD,  1'b0, 1'b0, WT_ADDR,  LAST_YES, NXT_END, 8'h00};
            4'd3:  u = '{SRC_ROW,   RS_CMD,  1'b0, 1'b0, WT_ADDR,  LAST_NO,  NXT_SEQ, 8'h00};
            4'd4:  u = '{SRC_CELL,  RS_DATA, 1'b0, 1'b0, WT_BYTE,  LAST_ROW, NXT_ROW, 8'h00};
            4'd5:  u = '{SRC_CONST, RS_CMD,  1'b1, 1'b1, WT_INIT0, LAST_NO,  NXT_SEQ, 8'h03};
            4'd6:  u = '{SRC_CONST, RS_CMD,  1'b1, 1'b0, WT_INIT1, LAST_NO,  NXT_SEQ, 8'h03};
            4'd7:  u = '{SRC_CONST, RS_CMD,  1'b1, 1'b0, WT_BYTE,  LAST_NO,  NXT_SEQ, 8'h03};
            4'd8:  u = '{SRC_CONST, RS_CMD,  1'b1, 1'b0, WT_BYTE,  LAST_NO,  NXT_SEQ, 8'h02};
            4'd9:  u = '{SRC_CONST, RS_CMD,  1'b0, 1'b0, WT_BYTE,  LAST_NO,  NXT_SEQ, 8'h28};
            4'd10: u = '{SRC_CONST, RS_CMD,  1'b0, 1'b0, WT_BYTE,  LAST_NO,  NXT_SEQ, 8'h08};
            4'd11: u = '{SRC_CONST, RS_CMD,  1'b0, 1'b0, WT_BYTE,  LAST_NO,  NXT_SEQ, 8'h06};
            4'd12: u = '{SRC_CONST, RS_CMD,  1'b0, 1'b0, WT_CLEAR, LAST_NO,  NXT_SEQ, 8'h01};
            4'd13: u = '{SRC_CONST, RS_CMD,  1'b0, 1'b0, WT_BYTE,  LAST_NO,  NXT_SEQ, 8'h0C};
            4'd14: u = '{SRC_CONST, RS_DATA, 1'b0, 1'b0, WT_BYTE,  LAST_YES, NXT_END, 8'hEB};
            default: u = '{SRC_CONST, RS_CMD, 1'b0, 1'b0, WT_BYTE, LAST_YES, NXT_END, 8'h00};
        endcase
        return u;
    endfunction

    function automatic logic [12:0] wait_value(input wait_sel_t w);
        logic [12:0] v;
        case (w)
            WT_BYTE:  v = WAIT_BYTE;
            WT_ADDR:  v = WAIT_ADDR;
            WT_CLEAR: v = WAIT_CLEAR;
            WT_INIT0: v = WAIT_INIT0;
            WT_INIT1: v = WAIT_INIT1;
            default:  v = WAIT_BYTE;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] row_ddram(input logic [1:0] row);
        logic [6:0] a;
        case (row)
            2'd0:    a = 7'd0;
            2'd1:    a = 7'd64;
            2'd2:    a = 7'd20;
            2'd3:    a = 7'd84;
            default: a = 7'd0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/clcd_buffer.sv @@
// Character buffer: one-port memory with per-cell valid bits; an invalid cell reads as a space.
module clcd_buffer #(
    parameter int BUFFER_CHARS = clcd_pkg::BUFFER_CHARS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  clcd_pkg::buf_cmd_t cmd,
    output logic [7:0]         cell_data
);
    import clcd_pkg::*;

    localparam int AW = $clog2(BUFFER_CHARS);

    logic [7:0]              mem [BUFFER_CHARS];
    logic [BUFFER_CHARS-1:0] valid_reg;
    logic [7:0]              mem_q_reg;
    logic                    hit_reg;
    logic                    in_range;
    logic [AW-1:0]           idx;

    assign in_range = cmd.addr < CELL_AW'(BUFFER_CHARS);
    assign idx      = cmd.addr[AW-1:0];

    // A cleared cell only drops its valid bit, which makes it read as a space.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (in_range) begin
            if (cmd.store) begin
                valid_reg[idx] <= 1'b1;
            end else if (cmd.clr) begin
                valid_reg[idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store && in_range) begin
            mem[idx] <= cmd.data;
        end
        if (cmd.rd) begin
            mem_q_reg <= mem[idx];
            hit_reg   <= in_range && valid_reg[idx];
        end
    end

    assign cell_data = hit_reg ? mem_q_reg : CHAR_SPACE;

endmodule

@@ rtl/char_lcd_4bit_interface_unit.sv @@
// Top level: microcoded nibble sequencer of the 4-bit character LCD interface.
// Each step fetches a microcode word and then emits its high and low nibble (the first init
// steps emit one nibble only); m_ready low stalls the emission. A row flush sends the row
// address and then each cell of the row; a new request is taken only while idle.
// Stores finish in their accept cycle. Reset clears the whole buffer to spaces at once
// through the valid bits; there is no clearing pass.
module char_lcd_4bit_interface_unit #(
    parameter int BUFFER_CHARS = clcd_pkg::BUFFER_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [6:0]  s_char_index,
    input  logic [1:0]  s_row_index,
    input  logic        s_rs_bit,
    input  logic [7:0]  s_byte_value,
    input  logic [6:0]  s_ram_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_rs_line,
    output logic [3:0]  m_nibble,
    output logic [15:0] m_wait_before,
    output logic [12:0] m_wait_after,
    output logic        m_last
);
    import clcd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_NIB0, ST_NIB1} state_t;

    state_t      state_reg;
    logic        panel_kind_reg;
    logic        clear_after_reg;
    logic [15:0] power_on_wait_reg;
    logic [3:0]  pc_reg;
    logic [4:0]  col_reg;
    logic [4:0]  col_last_reg;
    logic [6:0]  cell_addr_reg;
    logic [1:0]  row_reg;
    logic        rs_req_reg;
    logic [7:0]  byte_reg;
    logic [6:0]  addr_reg;

    logic        m_valid_reg;
    logic        m_rs_line_reg;
    logic [3:0]  m_nibble_reg;
    logic [15:0] m_wait_before_reg;
    logic [12:0] m_wait_after_reg;
    logic        m_last_reg;

    uop_t        uop;
    buf_cmd_t    buf_cmd;
    logic [7:0]  cell_data;
    logic [7:0]  byte_sel;
    logic        rs_sel;
    logic [3:0]  nib_sel;
    logic [12:0] wait_after_sel;
    logic [15:0] wait_before_sel;
    logic        last_sel;
    logic        slot_free;
    logic        emit;
    logic        step_done;
    logic        row_end;
    logic        s_take;
    logic        row_ok;
    logic [15:0] pow_stretched;
    logic [6:0]  row_base;

    assign uop       = uop_rom(pc_reg);
    assign slot_free = !m_valid_reg || m_ready;
    assign emit      = slot_free && (state_reg == ST_NIB0 || state_reg == ST_NIB1);
    assign step_done = (state_reg == ST_NIB1) || (state_reg == ST_NIB0 && uop.single);
    assign row_end   = col_reg == col_last_reg;
    assign s_ready   = state_reg == ST_IDLE;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign row_ok    = panel_kind_reg || !s_row_index[1];

    assign pow_stretched = (power_on_wait_reg < WAIT_SAT) ? power_on_wait_reg + 16'd1
                                                          : power_on_wait_reg;
    // Row start is row * 16 or row * 20.
    assign row_base = {1'b0, s_row_index, 4'b0000}
                    + (panel_kind_reg ? {3'b000, s_row_index, 2'b00} : 7'd0);

    always_comb begin
        buf_cmd.store = s_take && (s_req_type == REQ_STORE);
        buf_cmd.rd    = state_reg == ST_FETCH;
        buf_cmd.clr   = emit && step_done && (uop.src == SRC_CELL) && clear_after_reg;
        buf_cmd.addr  = (state_reg == ST_IDLE) ? s_char_index : cell_addr_reg;
        buf_cmd.data  = s_byte_value;
    end

    clcd_buffer #(
        .BUFFER_CHARS(BUFFER_CHARS)
    ) u_buffer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (buf_cmd),
        .cell_data (cell_data)
    );

    always_comb begin
        case (uop.src)
            SRC_CONST: byte_sel = uop.cbyte;
            SRC_RAW:   byte_sel = byte_reg;
            SRC_CGRAM: byte_sel = {2'b01, addr_reg[5:0]};
            SRC_DDRAM: byte_sel = {1'b1, addr_reg};
            SRC_ROW:   byte_sel = {1'b1, row_ddram(row_reg)};
            SRC_CELL:  byte_sel = cell_data;
            default:   byte_sel = uop.cbyte;
        endcase

        case (uop.rs)
            RS_CMD:  rs_sel = 1'b0;
            RS_DATA: rs_sel = 1'b1;
            RS_REQ:  rs_sel = rs_req_reg;
            default: rs_sel = 1'b0;
        endcase

        if (uop.single || state_reg == ST_NIB1) begin
            nib_sel = byte_sel[3:0];
        end else begin
            nib_sel = byte_sel[7:4];
        end

        wait_after_sel  = step_done ? wait_value(uop.wt) : WAIT_NIB;
        wait_before_sel = (uop.first && state_reg == ST_NIB0) ? pow_stretched : 16'd0;
        last_sel        = step_done && (uop.lst == LAST_YES || (uop.lst == LAST_ROW && row_end));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            panel_kind_reg    <= 1'b0;
            clear_after_reg   <= 1'b0;
            power_on_wait_reg <= POWER_ON_WAIT_RST;
            pc_reg            <= PC_RAW;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_PANEL_KIND:    panel_kind_reg    <= cfg_data[0];
                    REG_CLEAR_AFTER:   clear_after_reg   <= cfg_data[0];
                    REG_POWER_ON_WAIT: power_on_wait_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_take) begin
                        case (s_req_type)
                            REQ_FLUSH: begin
                                if (row_ok) begin
                                    pc_reg    <= PC_FLUSH;
                                    state_reg <= ST_FETCH;
                                end
                            end
                            REQ_INIT: begin
                                pc_reg    <= PC_INIT;
                                state_reg <= ST_FETCH;
                            end
                            REQ_RAW: begin
                                pc_reg    <= PC_RAW;
                                state_reg <= ST_FETCH;
                            end
                            REQ_CGRAM: begin
                                pc_reg    <= PC_CGRAM;
                                state_reg <= ST_FETCH;
                            end
                            REQ_DDRAM: begin
                                pc_reg    <= PC_DDRAM;
                                state_reg <= ST_FETCH;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_NIB0;
                end
                ST_NIB0, ST_NIB1: begin
                    if (emit) begin
                        if (!step_done) begin
                            state_reg <= ST_NIB1;
                        end else begin
                            case (uop.nxt)
                                NXT_SEQ: begin
                                    pc_reg    <= pc_reg + 4'd1;
                                    state_reg <= ST_FETCH;
                                end
                                NXT_ROW: begin
                                    state_reg <= row_end ? ST_IDLE : ST_FETCH;
                                end
                                default: state_reg <= ST_IDLE;
                            endcase
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Request payload and cell walk; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            rs_req_reg    <= s_rs_bit;
            byte_reg      <= s_byte_value;
            addr_reg      <= s_ram_address;
            row_reg       <= s_row_index;
            col_reg       <= 5'd0;
            col_last_reg  <= panel_kind_reg ? 5'd19 : 5'd15;
            cell_addr_reg <= row_base;
        end else if (emit && step_done && uop.nxt == NXT_ROW && !row_end) begin
            col_reg       <= col_reg + 5'd1;
            cell_addr_reg <= cell_addr_reg + 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_rs_line_reg     <= rs_sel;
            m_nibble_reg      <= nib_sel;
            m_wait_before_reg <= wait_before_sel;
            m_wait_after_reg  <= wait_after_sel;
            m_last_reg        <= last_sel;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rs_line     = m_rs_line_reg;
    assign m_nibble      = m_nibble_reg;
    assign m_wait_before = m_wait_before_reg;
    assign m_wait_after  = m_wait_after_reg;
    assign m_last        = m_last_reg;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of the 4-bit character LCD interface: predicted nibble beats vs. DUT.
module tb_top;
    import clcd_pkg::*;

    // Raw microsecond delays; the block stretches each by one tick.
    localparam int unsigned T_NIB_US   = 1;
    localparam int unsigned T_BYTE_US  = 60;
    localparam int unsigned T_ADDR_US  = 55;
    localparam int unsigned T_CLEAR_US = 2280;
    localparam int unsigned T_INIT0_US = 6150;
    localparam int unsigned T_INIT1_US = 150;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [2:0] REQ_BAD_6  = 3'd6;
    localparam logic [2:0] REQ_BAD_7  = 3'd7;

    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 8;
    localparam int BUF_CELLS    = BUFFER_CHARS_DEF;

    typedef struct packed {
        logic [2:0] req_type;
        logic [6:0] char_index;
        logic [1:0] row_index;
        logic       rs_bit;
        logic [7:0] byte_value;
        logic [6:0] ram_address;
    } lcd_req_t;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic [15:0] pre_us;
        logic [12:0] after;
        logic        last;
    } nibble_beat_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_data      = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type    = '0;
    logic [6:0]  s_char_index  = '0;
    logic [1:0]  s_row_index   = '0;
    logic        s_rs_bit      = 1'b0;
    logic [7:0]  s_byte_value  = '0;
    logic [6:0]  s_ram_address = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_rs_line;
    logic [3:0]  m_nibble;
    logic [15:0] m_wait_before;
    logic [12:0] m_wait_after;
    logic        m_last;

    char_lcd_4bit_interface_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_char_index  (s_char_index),
        .s_row_index   (s_row_index),
        .s_rs_bit      (s_rs_bit),
        .s_byte_value  (s_byte_value),
        .s_ram_address (s_ram_address),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rs_line     (m_rs_line),
        .m_nibble      (m_nibble),
        .m_wait_before (m_wait_before),
        .m_wait_after  (m_wait_after),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the display buffer and the registers.
    logic [7:0]  shadow_cells [BUF_CELLS];
    logic        panel_20x4     = 1'b0;
    logic        clear_on_send  = 1'b0;
    logic [15:0] power_up_us    = POWER_ON_WAIT_RST;

    lcd_req_t     request_q[$];
    nibble_beat_t pending_nibbles[$];
    lcd_req_t     cur_req;

    int errors       = 0;
    int reqs_taken   = 0;
    int beats_seen   = 0;
    int flushes_sent = 0;
    int inits_sent   = 0;
    int settings_run = 1;

    initial begin
        for (int i = 0; i < BUF_CELLS; i++) shadow_cells[i] = CHAR_SPACE;
    end

    function automatic logic [31:0] stretched(input logic [31:0] t);
        return (t < 32'd65534) ? t + 32'd1 : t;
    endfunction

    function automatic logic [7:0] shadow_read(input int unsigned idx);
        if (idx < BUF_CELLS) return shadow_cells[idx];
        return CHAR_SPACE;
    endfunction

    task automatic push_nibble(input logic rs, input logic [3:0] nib, input logic [31:0] pre_us,
                               input logic [31:0] after, input logic last);
        nibble_beat_t b;
        b.rs     = rs;
        b.nib    = nib;
        b.pre_us = pre_us[15:0];
        b.after  = after[12:0];
        b.last   = last;
        pending_nibbles.push_back(b);
    endtask

    // A byte is sent high nibble first; extra lengthens the wait after the low nibble.
    task automatic push_byte_nibbles(input logic rs, input logic [7:0] b, input logic [31:0] extra,
                                     input logic last);
        push_nibble(rs, b[7:4], 0, stretched(T_NIB_US), 1'b0);
        push_nibble(rs, b[3:0], 0, stretched(T_BYTE_US) + extra, last);
    endtask

    task automatic predict_nibbles(input lcd_req_t r);
        logic [7:0]  init_bytes [6];
        logic [6:0]  row_base_addr [4];
        int unsigned cols;
        int unsigned rows;
        int unsigned cell_idx;
        init_bytes    = '{8'h28, 8'h08, 8'h06, 8'h01, 8'h0C, 8'hEB};
        row_base_addr = '{7'd0, 7'd64, 7'd20, 7'd84};
        cols = panel_20x4 ? 20 : 16;
        rows = panel_20x4 ? 4 : 2;
        case (r.req_type)
            REQ_STORE: begin
                if (r.char_index < BUF_CELLS) shadow_cells[r.char_index] = r.byte_value;
            end
            REQ_FLUSH: begin
                if (r.row_index < rows) begin
                    flushes_sent++;
                    push_byte_nibbles(1'b0, {1'b1, row_base_addr[r.row_index]},
                                      stretched(T_ADDR_US), 1'b0);
                    for (int unsigned i = 0; i < cols; i++) begin
                        cell_idx = r.row_index * cols + i;
                        push_byte_nibbles(1'b1, shadow_read(cell_idx), 0, i + 1 == cols);
                        if (clear_on_send && cell_idx < BUF_CELLS)
                            shadow_cells[cell_idx] = CHAR_SPACE;
                    end
                end
            end
            REQ_INIT: begin
                inits_sent++;
                push_nibble(1'b0, 4'h3, stretched(power_up_us),
                            stretched(T_BYTE_US) + stretched(T_INIT0_US), 1'b0);
                push_nibble(1'b0, 4'h3, 0, stretched(T_BYTE_US) + stretched(T_INIT1_US), 1'b0);
                push_nibble(1'b0, 4'h3, 0, stretched(T_BYTE_US), 1'b0);
                push_nibble(1'b0, 4'h2, 0, stretched(T_BYTE_US), 1'b0);
                for (int k = 0; k < 6; k++) begin
                    push_byte_nibbles(k == 5, init_bytes[k],
                                      (init_bytes[k] == 8'h01) ? stretched(T_CLEAR_US) : 0,
                                      k == 5);
                end
            end
            REQ_RAW:
                push_byte_nibbles(r.rs_bit, r.byte_value, 0, 1'b1);
            REQ_CGRAM:
                push_byte_nibbles(1'b0, {2'b01, r.ram_address[5:0]}, stretched(T_ADDR_US), 1'b1);
            REQ_DDRAM:
                push_byte_nibbles(1'b0, {1'b1, r.ram_address}, stretched(T_ADDR_US), 1'b1);
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("beat %0d: %s mismatch, got 0x%0h, want 0x%0h", beats_seen, what, got, want);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_nibbles(cur_req);
                reqs_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    cur_req = request_q.pop_front();
                    s_req_type    <= cur_req.req_type;
                    s_char_index  <= cur_req.char_index;
                    s_row_index   <= cur_req.row_index;
                    s_rs_bit      <= cur_req.rs_bit;
                    s_byte_value  <= cur_req.byte_value;
                    s_ram_address <= cur_req.ram_address;
                    s_valid       <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor; m_ready follows a stall pattern that changes mode now and then.
    int unsigned ready_mode  = 0;
    int unsigned mode_left   = 50;
    int unsigned ready_phase = 0;

    always @(posedge aclk) begin
        nibble_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_nibbles.size() == 0) begin
                    report_mismatch("unexpected beat", m_nibble, 0);
                end else begin
                    want = pending_nibbles.pop_front();
                    if (m_rs_line !== want.rs) report_mismatch("rs_line", m_rs_line, want.rs);
                    if (m_nibble !== want.nib) report_mismatch("nibble", m_nibble, want.nib);
                    if (m_wait_before !== want.pre_us)
                        report_mismatch("wait_before", m_wait_before, want.pre_us);
                    if (m_wait_after !== want.after)
                        report_mismatch("wait_after", m_wait_after, want.after);
                    if (m_last !== want.last) report_mismatch("last", m_last, want.last);
                end
                beats_seen++;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            ready_phase++;
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (ready_phase % 5) == 0;
                default: m_ready <= (ready_phase % 16) >= 13;
            endcase
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_nibbles.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Unused fields of every request carry random bits.
    task automatic queue_req(input logic [2:0] kind, input int unsigned a, input int unsigned b);
        lcd_req_t r;
        r = lcd_req_t'(28'($urandom));
        r.req_type = kind;
        case (kind)
            REQ_STORE: begin
                r.char_index = 7'(a);
                r.byte_value = 8'(b);
            end
            REQ_FLUSH: r.row_index = 2'(a);
            REQ_RAW: begin
                r.rs_bit     = 1'(a);
                r.byte_value = 8'(b);
            end
            REQ_CGRAM, REQ_DDRAM: r.ram_address = 7'(a);
            default: ;
        endcase
        request_q.push_back(r);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PANEL_KIND:    panel_20x4    = data[0];
            REG_CLEAR_AFTER:   clear_on_send = data[0];
            REG_POWER_ON_WAIT: power_up_us   = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic panel, input logic clr, input logic [15:0] wait_us);
        cfg_write(REG_PANEL_KIND, {15'($urandom), panel});
        cfg_write(REG_CLEAR_AFTER, {15'($urandom), clr});
        cfg_write(REG_POWER_ON_WAIT, wait_us);
        settings_run++;
    endtask

    // Stores finish silently, so a short settle follows the last result beat.
    task automatic drain;
        while (request_q.size() != 0 || s_valid || pending_nibbles.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Random traffic: mostly stores and flushes so that flushed rows carry real content.
    task automatic queue_random_phase(input int count);
        int issued;
        int unsigned pick;
        issued = 0;
        while (issued < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 6) == 0) begin
                    queue_req(REQ_STORE, $urandom_range(BUF_CELLS, 127), $urandom_range(0, 255));
                end else begin
                    queue_req(REQ_STORE, $urandom_range(0, BUF_CELLS - 1), $urandom_range(0, 255));
                    issued++;
                end
            end else if (pick < 66) begin
                queue_req(REQ_FLUSH, $urandom_range(0, 3), 0);
                issued++;
            end else if (pick < 73) begin
                queue_req(REQ_INIT, 0, 0);
                issued++;
            end else if (pick < 85) begin
                queue_req(REQ_RAW, $urandom_range(0, 1), $urandom_range(0, 255));
                issued++;
            end else if (pick < 91) begin
                queue_req(REQ_CGRAM, $urandom_range(0, 127), 0);
                issued++;
            end else if (pick < 97) begin
                queue_req(REQ_DDRAM, $urandom_range(0, 127), 0);
                issued++;
            end else begin
                queue_req($urandom_range(0, 1) ? REQ_BAD_6 : REQ_BAD_7, 0, 0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: 16x2 panel, no clearing, default power-up wait.
        queue_req(REQ_FLUSH, 0, 0);
        queue_req(REQ_STORE, 0, 8'h00);
        queue_req(REQ_STORE, 15, 8'hFF);
        queue_req(REQ_STORE, 16, 8'hA5);
        queue_req(REQ_STORE, 79, 8'h5A);
        queue_req(REQ_STORE, 80, 8'h11);
        queue_req(REQ_STORE, 127, 8'h22);
        queue_req(REQ_FLUSH, 0, 0);
        queue_req(REQ_FLUSH, 1, 0);
        queue_req(REQ_FLUSH, 2, 0);
        queue_req(REQ_FLUSH, 3, 0);
        queue_req(REQ_INIT, 0, 0);
        queue_req(REQ_RAW, 0, 8'h00);
        queue_req(REQ_RAW, 1, 8'hFF);
        queue_req(REQ_CGRAM, 0, 0);
        queue_req(REQ_CGRAM, 127, 0);
        queue_req(REQ_DDRAM, 0, 0);
        queue_req(REQ_DDRAM, 127, 0);
        queue_req(REQ_BAD_6, 0, 0);
        queue_req(REQ_BAD_7, 0, 0);
        drain();

        // 20x4 panel with clearing; the second flush of a row must come back blank.
        cfg_write(REG_UNUSED, 16'($urandom));
        apply_setting(1'b1, 1'b1, 16'hFFFF);
        queue_req(REQ_INIT, 0, 0);
        queue_req(REQ_STORE, 60, 8'h41);
        queue_req(REQ_FLUSH, 3, 0);
        queue_req(REQ_FLUSH, 3, 0);
        queue_req(REQ_FLUSH, 2, 0);
        queue_req(REQ_FLUSH, 0, 0);
        drain();

        apply_setting(1'b0, 1'b0, 16'd65534);
        queue_req(REQ_INIT, 0, 0);
        drain();
        apply_setting(1'b1, 1'b0, 16'd0);
        queue_req(REQ_INIT, 0, 0);
        drain();

        apply_setting(1'b1, 1'b0, 16'd65533);
        queue_random_phase(30);
        drain();
        apply_setting(1'b0, 1'b1, 16'd0);
        queue_random_phase(30);
        drain();
        apply_setting(1'b1, 1'b1, 16'($urandom));
        queue_random_phase(30);
        drain();
        apply_setting(1'b0, 1'b0, 16'hFFFF);
        queue_random_phase(30);
        drain();

        $display("Run covered %0d requests, %0d row flushes and %0d init sequences,",
                 reqs_taken, flushes_sent, inits_sent);
        $display("with %0d nibble beats checked across %0d register settings.",
                 beats_seen, settings_run);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/clcd_pkg.sv
rtl/clcd_buffer.sv
rtl/char_lcd_4bit_interface_unit.sv
verif/tb_top.sv
